/* design/mwrm_pkg.sv */
`default_nettype none
package mwrm_pkg;

    localparam int METERS_DEF        = 4;
    localparam int FRACTION_BITS_DEF = 8;

    localparam int SEC_W      = 32;
    localparam int LEN_W      = 16;
    localparam int AMT_W      = 32;
    localparam int SUM_W      = 48;
    localparam int RATE_W     = 56;
    localparam int CMD_W      = 2;
    localparam int QIDX_W     = 2;
    localparam int IN_DATA_W  = 40;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 16;
    localparam int METERS_W   = 3;
    localparam int CNT_CMP_W  = 4;

    // only the first four meters have a window length register
    localparam int NUM_LEN_REGS = 4;

    localparam logic [CFG_IDX_W-1:0] REG_SMOOTH = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_METERS = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_LEN0   = 3'd2;

    localparam logic [SEC_W-1:0] SMOOTH_DIVISOR = 32'd3;

    typedef enum logic [CMD_W-1:0] {
        CMD_ADD   = 2'd0,
        CMD_TICK  = 2'd1,
        CMD_QUERY = 2'd2,
        CMD_NONE  = 2'd3
    } t_cmd;

endpackage
`default_nettype wire

/* design/multi_window_rate_meter_top.sv */
`default_nettype none
// sequence: a tick only advances the seconds counter; add and query first scan each in-use meter, and
// each expired meter costs one or two serial divisions on the shared DVD_W-bit divider
// (DVD_W = max(48+FRACTION_BITS, 58), 58 by default); add then updates the sum of each in-use meter,
// a query reads the smoothed rate or runs one more division, then loads the result register
// throughput: one item at a time, bound by the shared bit-serial divider (1 bit per cycle)
// reset: synchronous active low; clears the counter, sums, rates and config, marks meters unrotated
module multi_window_rate_meter_top #(
    parameter int METERS        = mwrm_pkg::METERS_DEF,
    parameter int FRACTION_BITS = mwrm_pkg::FRACTION_BITS_DEF
) (
    input  wire logic                            i_clk,
    input  wire logic                            i_rst_n,
    // input stream
    input  wire logic                            i_s_tvalid,
    output logic                                 o_s_tready,
    input  wire logic [mwrm_pkg::IN_DATA_W-1:0]  i_s_tdata,   // add_amount[31:0], meter_index[33:32]
    input  wire logic [mwrm_pkg::CMD_W-1:0]      i_s_tuser,   // cmd[1:0]
    // result stream
    output logic                                 o_m_tvalid,
    input  wire logic                            i_m_tready,
    output logic [mwrm_pkg::RATE_W-1:0]          o_m_tdata,   // rate_value[55:0]
    output logic [0:0]                           o_m_tuser,   // rate_valid[0]
    // config writes
    input  wire logic                            i_cfg_valid,
    output logic                                 o_cfg_ready,
    input  wire logic [mwrm_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  wire logic [mwrm_pkg::CFG_DATA_W-1:0] i_cfg_data
);

    localparam int SUM_W    = mwrm_pkg::SUM_W;
    localparam int RATE_W   = mwrm_pkg::RATE_W;
    localparam int SEC_W    = mwrm_pkg::SEC_W;
    localparam int LEN_W    = mwrm_pkg::LEN_W;
    localparam int AMT_W    = mwrm_pkg::AMT_W;
    localparam int CMP_W    = mwrm_pkg::CNT_CMP_W;
    localparam int DIV_W    = SUM_W + FRACTION_BITS;
    localparam int SMOOTH_W = RATE_W + 2;
    localparam int DVD_W    = (DIV_W > SMOOTH_W) ? DIV_W : SMOOTH_W;
    localparam int IDX_W    = (METERS > 1) ? $clog2(METERS) : 1;
    localparam int CNT_W    = $clog2(METERS + 1);

    typedef enum logic [2:0] {
        S_IDLE,
        S_ROT_CHK,
        S_ROT_DIV,
        S_SMOOTH_DIV,
        S_ADD,
        S_QUERY,
        S_QUERY_DIV,
        S_EMIT
    } t_state;

    t_state r_state;

    logic                          r_smooth_mode;
    logic [mwrm_pkg::METERS_W-1:0] r_meters;
    logic [LEN_W-1:0]              r_len    [METERS];
    logic [SEC_W-1:0]              r_sec;
    logic [SEC_W-1:0]              r_start  [METERS];
    logic [SUM_W-1:0]              r_sum    [METERS];
    logic [RATE_W-1:0]             r_smooth [METERS];
    logic                          r_nyr    [METERS];

    logic                          r_is_query;
    logic [AMT_W-1:0]              r_amount;
    logic [IDX_W-1:0]              r_qidx;
    logic [CNT_W-1:0]              r_m;
    logic [RATE_W-1:0]             r_res;
    logic                          r_res_valid;
    logic                          r_out_valid;
    logic [RATE_W-1:0]             r_out_data;
    logic                          r_out_flag;

    logic                          r_div_start;
    logic                          n_div_start;
    logic [DVD_W-1:0]              r_div_dividend;
    logic [SEC_W-1:0]              r_div_divisor;
    logic                          w_div_done;
    logic [DVD_W-1:0]              w_div_quot;

    logic [CMP_W-1:0]              w_active;
    logic [IDX_W-1:0]              w_sel;
    logic [SEC_W-1:0]              w_elapsed;
    logic                          w_expired;
    logic                          w_m_done;
    logic [SUM_W:0]                w_sum_add;
    logic [SUM_W-1:0]              w_sum_sat;
    logic [RATE_W-1:0]             w_qsat;
    logic [DVD_W-1:0]              w_sum_shift;
    logic                          w_in_acc;
    logic [mwrm_pkg::QIDX_W-1:0]   w_in_idx;

    mwrm_div #(
        .DVD_W (DVD_W),
        .DSR_W (SEC_W)
    ) u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (r_div_start),
        .i_dividend (r_div_dividend),
        .i_divisor  (r_div_divisor),
        .o_done     (w_div_done),
        .o_quot     (w_div_quot)
    );

    // meters_in_use above METERS acts as METERS
    assign w_active  = (CMP_W'(r_meters) > CMP_W'(METERS)) ? CMP_W'(METERS) : CMP_W'(r_meters);
    assign w_sel     = (r_state == S_QUERY) ? r_qidx : r_m[IDX_W-1:0];
    assign w_elapsed = r_sec - r_start[w_sel];
    assign w_expired = (r_len[w_sel] != '0) && (w_elapsed >= SEC_W'(r_len[w_sel]));
    assign w_m_done  = (CMP_W'(r_m) >= w_active);
    assign w_sum_add = {1'b0, r_sum[w_sel]} + (SUM_W + 1)'(r_amount);
    assign w_sum_sat = w_sum_add[SUM_W] ? {SUM_W{1'b1}} : w_sum_add[SUM_W-1:0];
    assign w_qsat    = (|w_div_quot[DVD_W-1:RATE_W]) ? {RATE_W{1'b1}} : w_div_quot[RATE_W-1:0];
    assign w_sum_shift = DVD_W'(r_sum[w_sel]) << FRACTION_BITS;

    assign o_s_tready = (r_state == S_IDLE);
    assign w_in_acc   = i_s_tvalid && o_s_tready;
    assign w_in_idx   = i_s_tdata[AMT_W+mwrm_pkg::QIDX_W-1:AMT_W];

    assign o_cfg_ready = 1'b1;
    assign o_m_tvalid  = r_out_valid;
    assign o_m_tdata   = r_out_data;
    assign o_m_tuser   = r_out_flag;

    // divider kick: window rate, smoothing step, or query rate
    always_comb begin
        case (r_state)
            S_ROT_CHK: n_div_start = !w_m_done && w_expired;
            S_ROT_DIV: n_div_start = w_div_done && (r_smooth[w_sel] != '0);
            S_QUERY:   n_div_start = !(r_smooth_mode && !r_nyr[w_sel]);
            default:   n_div_start = 1'b0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state       <= S_IDLE;
            r_smooth_mode <= 1'b0;
            r_meters      <= '0;
            r_sec         <= '0;
            r_out_valid   <= 1'b0;
            r_div_start   <= 1'b0;
            r_is_query    <= 1'b0;
            r_m           <= '0;
            for (int i = 0; i < METERS; i++) begin
                r_len[i]    <= '0;
                r_start[i]  <= '0;
                r_sum[i]    <= '0;
                r_smooth[i] <= '0;
                r_nyr[i]    <= 1'b1;
            end
        end else begin
            if (i_cfg_valid) begin
                case (i_cfg_index)
                    mwrm_pkg::REG_SMOOTH: r_smooth_mode <= i_cfg_data[0];
                    mwrm_pkg::REG_METERS: r_meters <= i_cfg_data[mwrm_pkg::METERS_W-1:0];
                    default: ;
                endcase
                for (int i = 0; i < METERS; i++) begin
                    if (i < mwrm_pkg::NUM_LEN_REGS &&
                        i_cfg_index == mwrm_pkg::REG_LEN0 + mwrm_pkg::CFG_IDX_W'(i)) begin
                        r_len[i] <= i_cfg_data;
                    end
                end
            end

            // the emit state reloads the output register itself
            if (r_out_valid && i_m_tready && r_state != S_EMIT) begin
                r_out_valid <= 1'b0;
            end

            r_div_start <= n_div_start;

            case (r_state)
                S_IDLE: begin
                    if (w_in_acc) begin
                        case (mwrm_pkg::t_cmd'(i_s_tuser))
                            mwrm_pkg::CMD_TICK: begin
                                r_sec <= r_sec + SEC_W'(1);
                            end
                            mwrm_pkg::CMD_ADD: begin
                                r_amount   <= i_s_tdata[AMT_W-1:0];
                                r_is_query <= 1'b0;
                                r_m        <= '0;
                                r_state    <= S_ROT_CHK;
                            end
                            mwrm_pkg::CMD_QUERY: begin
                                if (CMP_W'(w_in_idx) >= w_active) begin
                                    // unused meter: no rotation, invalid result
                                    r_res       <= '0;
                                    r_res_valid <= 1'b0;
                                    r_state     <= S_EMIT;
                                end else begin
                                    r_qidx     <= IDX_W'(w_in_idx);
                                    r_is_query <= 1'b1;
                                    r_m        <= '0;
                                    r_state    <= S_ROT_CHK;
                                end
                            end
                            default: ;
                        endcase
                    end
                end
                S_ROT_CHK: begin
                    if (w_m_done) begin
                        r_m     <= '0;
                        r_state <= r_is_query ? S_QUERY : S_ADD;
                    end else if (w_expired) begin
                        r_div_dividend <= w_sum_shift;
                        r_div_divisor  <= SEC_W'(r_len[w_sel]);
                        r_state        <= S_ROT_DIV;
                    end else begin
                        r_m <= r_m + CNT_W'(1);
                    end
                end
                S_ROT_DIV: begin
                    if (w_div_done) begin
                        if (r_smooth[w_sel] == '0) begin
                            r_smooth[w_sel] <= w_qsat;
                            r_start[w_sel]  <= r_sec;
                            r_sum[w_sel]    <= '0;
                            r_nyr[w_sel]    <= 1'b0;
                            r_m             <= r_m + CNT_W'(1);
                            r_state         <= S_ROT_CHK;
                        end else begin
                            // (2*rate + old) / 3 on the same divider
                            r_div_dividend <= (DVD_W'(w_qsat) << 1) + DVD_W'(r_smooth[w_sel]);
                            r_div_divisor  <= mwrm_pkg::SMOOTH_DIVISOR;
                            r_state        <= S_SMOOTH_DIV;
                        end
                    end
                end
                S_SMOOTH_DIV: begin
                    if (w_div_done) begin
                        r_smooth[w_sel] <= w_div_quot[RATE_W-1:0];
                        r_start[w_sel]  <= r_sec;
                        r_sum[w_sel]    <= '0;
                        r_nyr[w_sel]    <= 1'b0;
                        r_m             <= r_m + CNT_W'(1);
                        r_state         <= S_ROT_CHK;
                    end
                end
                S_ADD: begin
                    if (w_m_done) begin
                        r_state <= S_IDLE;
                    end else begin
                        r_sum[w_sel] <= w_sum_sat;
                        r_m          <= r_m + CNT_W'(1);
                    end
                end
                S_QUERY: begin
                    if (r_smooth_mode && !r_nyr[w_sel]) begin
                        r_res       <= r_smooth[w_sel];
                        r_res_valid <= 1'b1;
                        r_state     <= S_EMIT;
                    end else begin
                        r_div_dividend <= w_sum_shift;
                        r_div_divisor  <= (w_elapsed == '0) ? SEC_W'(1) : w_elapsed;
                        r_state        <= S_QUERY_DIV;
                    end
                end
                S_QUERY_DIV: begin
                    if (w_div_done) begin
                        r_res       <= w_qsat;
                        r_res_valid <= 1'b1;
                        r_state     <= S_EMIT;
                    end
                end
                S_EMIT: begin
                    if (!r_out_valid || i_m_tready) begin
                        r_out_valid <= 1'b1;
                        r_out_data  <= r_res;
                        r_out_flag  <= r_res_valid;
                        r_state     <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

endmodule
`default_nettype wire

/* design/mwrm_div.sv */
`default_nettype none
// bit-serial restoring divider: one quotient bit per cycle
module mwrm_div #(
    parameter int DVD_W = 64,
    parameter int DSR_W = mwrm_pkg::SEC_W
) (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_start,
    input  wire logic [DVD_W-1:0] i_dividend,
    input  wire logic [DSR_W-1:0] i_divisor,
    output logic                  o_done,
    output logic [DVD_W-1:0]      o_quot
);

    localparam int CNT_W = (DVD_W > 1) ? $clog2(DVD_W) : 1;

    logic             r_busy;
    logic             r_done;
    logic [CNT_W-1:0] r_cnt;
    logic [DSR_W-1:0] r_rem;
    logic [DSR_W-1:0] r_dsr;
    logic [DVD_W-1:0] r_quo;

    logic [DSR_W:0]   w_trial;
    logic [DSR_W:0]   w_diff;
    logic             w_ge;

    assign w_trial = {r_rem, r_quo[DVD_W-1]};
    assign w_diff  = w_trial - {1'b0, r_dsr};
    assign w_ge    = (w_trial >= {1'b0, r_dsr});

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            if (i_start) begin
                r_busy <= 1'b1;
                r_done <= 1'b0;
                r_cnt  <= CNT_W'(DVD_W - 1);
                r_rem  <= '0;
                r_dsr  <= i_divisor;
                r_quo  <= i_dividend;
            end else if (r_busy) begin
                // remainder stays below divisor, so the low bits are enough
                r_rem  <= w_ge ? w_diff[DSR_W-1:0] : w_trial[DSR_W-1:0];
                r_quo  <= {r_quo[DVD_W-2:0], w_ge};
                r_cnt  <= r_cnt - CNT_W'(1);
                r_done <= (r_cnt == '0);
                if (r_cnt == '0) begin
                    r_busy <= 1'b0;
                end
            end else begin
                r_done <= 1'b0;
            end
        end
    end

    assign o_done = r_done;
    assign o_quot = r_quo;

endmodule
`default_nettype wire
